[rtl/pf_pkg.sv]
// Shared types, constants and helper functions for the Playfair cipher engine.
package pf_pkg;

   localparam logic [4:0] CELLS       = 5'd25;
   localparam logic [4:0] LAST_LETTER = 5'd25;
   localparam logic [4:0] FOLD_FROM   = 5'd8;
   localparam logic [4:0] FOLD_TO     = 5'd9;
   localparam logic [2:0] SIDE        = 3'd5;
   localparam logic [2:0] STEP_ENC    = 3'd1;
   localparam logic [2:0] STEP_DEC    = SIDE - 3'd1;

   typedef enum logic [1:0] {
      OP_KEY    = 2'd0,
      OP_FINISH = 2'd1,
      OP_ENC    = 2'd2,
      OP_DEC    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_IGNORED   = 2'd1,
      STAT_NOT_READY = 2'd2,
      STAT_RSVD      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FILL,
      S_POS,
      S_CELL,
      S_EMIT
   } state_type;

   // one classified item waiting for the back end
   typedef struct packed {
      op_type     op;
      logic [4:0] b;
      logic [4:0] a;
   } item_type;

   // result word, out_a in the lowest bits
   typedef struct packed {
      status_type status;
      logic [4:0] out_b;
      logic [4:0] out_a;
   } result_type;

   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
   } rc_type;

   // saturate to z, fold i into j
   function automatic logic [4:0] norm_letter(input logic [4:0] v);
      logic [4:0] l;
      l = (v > LAST_LETTER) ? LAST_LETTER : v;
      if (l == FOLD_FROM) begin
         l = FOLD_TO;
      end
      return l;
   endfunction

   // cell index to row/column; row = p*13 >> 6 is exact for p < 25
   function automatic rc_type cell_rc(input logic [4:0] p);
      logic [4:0] pc;
      logic [8:0] prod;
      logic [4:0] rem;
      rc_type     rc;
      pc      = (p < CELLS) ? p : 5'd0;
      prod    = {4'd0, pc} * 9'd13;
      rc.row  = prod[8:6];
      rem     = pc - ({2'd0, rc.row} << 2) - {2'd0, rc.row};
      rc.col  = rem[2:0];
      return rc;
   endfunction

   function automatic logic [2:0] wrap_add(input logic [2:0] v, input logic [2:0] step);
      logic [3:0] s;
      s = {1'b0, v} + {1'b0, step};
      if (s >= {1'b0, SIDE}) begin
         s = s - {1'b0, SIDE};
      end
      return s[2:0];
   endfunction

   function automatic logic [4:0] cell_index(input rc_type rc);
      return ({2'd0, rc.row} << 2) + {2'd0, rc.row} + {2'd0, rc.col};
   endfunction

endpackage

[rtl/pf_front.sv]
// Front end: takes request transactions, normalizes letters and classifies the operation.
module pf_front (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_tuser,   // [1:0] mode
   input  logic [15:0]       req_tdata,   // [4:0] letter_a, [9:5] letter_b, [15:10] zero
   input  logic              queue_full,
   output logic              push,
   output pf_pkg::item_type  push_item
);

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_item.op = pf_pkg::op_type'(req_tuser);
      push_item.a  = pf_pkg::norm_letter(req_tdata[4:0]);
      push_item.b  = pf_pkg::norm_letter(req_tdata[9:5]);
   end

endmodule

[rtl/pf_queue.sv]
// Two-entry queue between the front end and the back end.
module pf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pf_pkg::item_type  push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output pf_pkg::item_type  head_item
);

   pf_pkg::item_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/pf_back.sv]
// Back end: key square storage, fill sequencer, pair lookup and result register.
module pf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  pf_pkg::item_type  head_item,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata
);

   pf_pkg::state_type  state_ff, state_in;
   pf_pkg::op_type     op_ff, op_in;
   pf_pkg::result_type res_ff, res_in;
   pf_pkg::result_type out_ff;
   logic               out_valid_ff;
   logic [25:0]        used_ff;
   logic [4:0]         fill_ff;
   logic               ready_ff;
   logic [4:0]         let_ff;

   // key square and letter position memories
   logic [4:0] square_mem [25];
   logic [4:0] pos_mem [26];
   logic [4:0] pos_a_ff, pos_b_ff;
   logic [4:0] cell_a_ff, cell_b_ff;

   logic       wr_en;
   logic [4:0] wr_letter;
   logic       pos_rd_en;
   logic       cell_rd_en;
   logic       out_load;
   logic       fill_last;

   pf_pkg::rc_type rc_a, rc_b;
   logic [2:0]     step;
   logic [4:0]     idx_a, idx_b;

   assign fill_last = (let_ff == pf_pkg::LAST_LETTER);
   assign out_load  = (state_ff == pf_pkg::S_EMIT) && (!out_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pf_pkg::S_IDLE: begin
            if (head_valid) begin
               unique case (head_item.op)
                  pf_pkg::OP_KEY:    state_in = pf_pkg::S_EMIT;
                  pf_pkg::OP_FINISH: state_in = ready_ff ? pf_pkg::S_EMIT : pf_pkg::S_FILL;
                  pf_pkg::OP_ENC,
                  pf_pkg::OP_DEC:    state_in = ready_ff ? pf_pkg::S_POS : pf_pkg::S_EMIT;
                  default:           state_in = pf_pkg::S_EMIT;
               endcase
            end
         end
         pf_pkg::S_FILL: begin
            if (fill_last) begin
               state_in = pf_pkg::S_EMIT;
            end
         end
         pf_pkg::S_POS:  state_in = pf_pkg::S_CELL;
         pf_pkg::S_CELL: state_in = pf_pkg::S_EMIT;
         pf_pkg::S_EMIT: begin
            if (out_load) begin
               state_in = pf_pkg::S_IDLE;
            end
         end
         default: state_in = pf_pkg::S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop        = 1'b0;
      wr_en      = 1'b0;
      wr_letter  = head_item.a;
      pos_rd_en  = 1'b0;
      cell_rd_en = 1'b0;
      op_in      = op_ff;
      res_in     = res_ff;
      unique case (state_ff)
         pf_pkg::S_IDLE: begin
            if (head_valid) begin
               pop          = 1'b1;
               op_in        = head_item.op;
               res_in.out_a = 5'd0;
               res_in.out_b = 5'd0;
               res_in.status = pf_pkg::STAT_OK;
               unique case (head_item.op)
                  pf_pkg::OP_KEY: begin
                     if (ready_ff || fill_ff >= pf_pkg::CELLS || used_ff[head_item.a]) begin
                        res_in.status = pf_pkg::STAT_IGNORED;
                     end else begin
                        wr_en = 1'b1;
                     end
                  end
                  pf_pkg::OP_FINISH: ;
                  pf_pkg::OP_ENC,
                  pf_pkg::OP_DEC: begin
                     if (ready_ff) begin
                        pos_rd_en = 1'b1;
                     end else begin
                        res_in.status = pf_pkg::STAT_NOT_READY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         pf_pkg::S_FILL: begin
            wr_letter = let_ff;
            wr_en     = (let_ff != pf_pkg::FOLD_FROM) && !used_ff[let_ff]
                        && (fill_ff < pf_pkg::CELLS);
         end
         pf_pkg::S_POS: cell_rd_en = 1'b1;
         pf_pkg::S_CELL: begin
            res_in.out_a  = cell_a_ff;
            res_in.out_b  = cell_b_ff;
            res_in.status = pf_pkg::STAT_OK;
         end
         pf_pkg::S_EMIT: ;
         default: ;
      endcase
   end

   // pair rules on the looked-up positions
   always_comb begin
      pf_pkg::rc_type ra, rb;
      ra   = pf_pkg::cell_rc(pos_a_ff);
      rb   = pf_pkg::cell_rc(pos_b_ff);
      step = (op_ff == pf_pkg::OP_ENC) ? pf_pkg::STEP_ENC : pf_pkg::STEP_DEC;
      rc_a = ra;
      rc_b = rb;
      if (ra.row == rb.row) begin
         rc_a.col = pf_pkg::wrap_add(ra.col, step);
         rc_b.col = pf_pkg::wrap_add(rb.col, step);
      end else if (ra.col == rb.col) begin
         rc_a.row = pf_pkg::wrap_add(ra.row, step);
         rc_b.row = pf_pkg::wrap_add(rb.row, step);
      end else begin
         rc_a.col = rb.col;
         rc_b.col = ra.col;
      end
      idx_a = pf_pkg::cell_index(rc_a);
      idx_b = pf_pkg::cell_index(rc_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pf_pkg::S_IDLE;
         used_ff      <= '0;
         fill_ff      <= 5'd0;
         ready_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            used_ff[wr_letter] <= 1'b1;
            fill_ff            <= fill_ff + 5'd1;
         end
         if (state_ff == pf_pkg::S_FILL && fill_last) begin
            ready_ff <= 1'b1;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      res_ff <= res_in;
      if (pop) begin
         let_ff <= 5'd0;
      end else if (state_ff == pf_pkg::S_FILL) begin
         let_ff <= let_ff + 5'd1;
      end
      if (out_load) begin
         out_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         square_mem[fill_ff] <= wr_letter;
         pos_mem[wr_letter]  <= fill_ff;
      end
      if (pos_rd_en) begin
         pos_a_ff <= pos_mem[head_item.a];
         pos_b_ff <= pos_mem[head_item.b];
      end
      if (cell_rd_en) begin
         cell_a_ff <= square_mem[idx_a];
         cell_b_ff <= square_mem[idx_b];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff};

endmodule

[rtl/playfair_digraph_cipher.sv]
// Top level of the Playfair cipher engine with a 5x5 key square.
//
// Request channel (req_): tuser carries the mode, tdata the two letters coded 0..25.
// Mode 0 adds a key letter, mode 1 completes the square with the remaining letters,
// modes 2 and 3 encrypt or decrypt one letter pair. Letters above 25 saturate to z
// and i is folded into j. Every request transaction yields exactly one response
// transaction (rsp_) carrying out_a, out_b and a status code, in request order.
// The back-end sequencer handles one request at a time: a key letter is written
// directly, a pair steps through position read, square read and result, and
// completing the square walks all 26 letters one per cycle with a single write
// port on the square. A two-entry queue lets requests be taken while the back end
// is busy or a response waits. When rsp_tready is low the response is held stable
// in the output register and the queue fills, then req_tready drops.
// Reset clears the square state (no letters used, not finished) and the queue;
// the square must be rebuilt before pairs are accepted with status ok.
module playfair_digraph_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic [15:0] req_tdata,   // [4:0] letter_a, [9:5] letter_b, [15:10] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [4:0] out_a, [9:5] out_b, [11:10] status, [15:12] zero
);

   logic             push;
   logic             queue_full;
   logic             pop;
   logic             head_valid;
   pf_pkg::item_type push_item;
   pf_pkg::item_type head_item;

   pf_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   pf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   pf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
